FILE: design/attenuated_sine_from_phase_core_defines.svh
// assertion helpers for the design files, used by the command queue
`ifndef ATTENUATED_SINE_FROM_PHASE_CORE_DEFINES_SVH
`define ATTENUATED_SINE_FROM_PHASE_CORE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define ASFP_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property whose condition in one cycle implies a consequence in the next
`define ASFP_CHECK_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: design/asfp_pkg.sv
package asfp_pkg;

	localparam logic [15:0] PH_QUARTER = 16'h4000;
	localparam logic [15:0] PH_HALF    = 16'h8000;
	localparam logic [15:0] PH_3QUART  = 16'hC000;
	localparam logic [14:0] POS_FULL   = 15'h7FFF;
	localparam logic [15:0] NEG_FULL   = 16'h8000;

	localparam int unsigned QUEUE_DEPTH = 4;

	// classification of a word by the front part
	localparam logic [1:0] KIND_NORM     = 2'd0;
	localparam logic [1:0] KIND_POS_FULL = 2'd1;
	localparam logic [1:0] KIND_NEG_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic        neg;
		logic [13:0] ph;
		logic [15:0] att;
	} cmd_t;

	// quarter-wave sine, UQ0.16
	localparam logic [15:0] QUARTER_ROM [256] = '{
		16'h0000, 16'h0192, 16'h0324, 16'h04B6, 16'h0648, 16'h07DA, 16'h096C, 16'h0AFE,
		16'h0C90, 16'h0E21, 16'h0FB3, 16'h1144, 16'h12D5, 16'h1466, 16'h15F7, 16'h1787,
		16'h1918, 16'h1AA8, 16'h1C38, 16'h1DC7, 16'h1F56, 16'h20E5, 16'h2274, 16'h2402,
		16'h2590, 16'h271E, 16'h28AB, 16'h2A38, 16'h2BC4, 16'h2D50, 16'h2EDC, 16'h3067,
		16'h31F1, 16'h337C, 16'h3505, 16'h368E, 16'h3817, 16'h399F, 16'h3B27, 16'h3CAE,
		16'h3E34, 16'h3FBA, 16'h413F, 16'h42C3, 16'h4447, 16'h45CB, 16'h474D, 16'h48CF,
		16'h4A50, 16'h4BD1, 16'h4D50, 16'h4ECF, 16'h504D, 16'h51CB, 16'h5348, 16'h54C3,
		16'h563E, 16'h57B9, 16'h5932, 16'h5AAA, 16'h5C22, 16'h5D99, 16'h5F0F, 16'h6084,
		16'h61F8, 16'h636B, 16'h64DD, 16'h664E, 16'h67BE, 16'h692D, 16'h6A9B, 16'h6C08,
		16'h6D74, 16'h6EDF, 16'h7049, 16'h71B2, 16'h731A, 16'h7480, 16'h75E6, 16'h774A,
		16'h78AD, 16'h7A10, 16'h7B70, 16'h7CD0, 16'h7E2F, 16'h7F8C, 16'h80E8, 16'h8243,
		16'h839C, 16'h84F5, 16'h864C, 16'h87A1, 16'h88F6, 16'h8A49, 16'h8B9A, 16'h8CEB,
		16'h8E3A, 16'h8F88, 16'h90D4, 16'h921F, 16'h9368, 16'h94B0, 16'h95F7, 16'h973C,
		16'h9880, 16'h99C2, 16'h9B03, 16'h9C42, 16'h9D80, 16'h9EBC, 16'h9FF7, 16'hA130,
		16'hA268, 16'hA39E, 16'hA4D2, 16'hA605, 16'hA736, 16'hA866, 16'hA994, 16'hAAC1,
		16'hABEB, 16'hAD14, 16'hAE3C, 16'hAF62, 16'hB086, 16'hB1A8, 16'hB2C9, 16'hB3E8,
		16'hB505, 16'hB620, 16'hB73A, 16'hB852, 16'hB968, 16'hBA7D, 16'hBB8F, 16'hBCA0,
		16'hBDAF, 16'hBEBC, 16'hBFC7, 16'hC0D1, 16'hC1D8, 16'hC2DE, 16'hC3E2, 16'hC4E4,
		16'hC5E4, 16'hC6E2, 16'hC7DE, 16'hC8D9, 16'hC9D1, 16'hCAC7, 16'hCBBC, 16'hCCAE,
		16'hCD9F, 16'hCE8E, 16'hCF7A, 16'hD065, 16'hD14D, 16'hD234, 16'hD318, 16'hD3FB,
		16'hD4DB, 16'hD5BA, 16'hD696, 16'hD770, 16'hD848, 16'hD91E, 16'hD9F2, 16'hDAC4,
		16'hDB94, 16'hDC62, 16'hDD2D, 16'hDDF7, 16'hDEBE, 16'hDF83, 16'hE046, 16'hE107,
		16'hE1C6, 16'hE282, 16'hE33C, 16'hE3F4, 16'hE4AA, 16'hE55E, 16'hE610, 16'hE6BF,
		16'hE76C, 16'hE817, 16'hE8BF, 16'hE966, 16'hEA0A, 16'hEAAB, 16'hEB4B, 16'hEBE8,
		16'hEC83, 16'hED1C, 16'hEDB3, 16'hEE47, 16'hEED9, 16'hEF68, 16'hEFF5, 16'hF080,
		16'hF109, 16'hF18F, 16'hF213, 16'hF295, 16'hF314, 16'hF391, 16'hF40C, 16'hF484,
		16'hF4FA, 16'hF56E, 16'hF5DF, 16'hF64E, 16'hF6BA, 16'hF724, 16'hF78C, 16'hF7F1,
		16'hF854, 16'hF8B4, 16'hF913, 16'hF96E, 16'hF9C8, 16'hFA1F, 16'hFA73, 16'hFAC5,
		16'hFB15, 16'hFB62, 16'hFBAD, 16'hFBF5, 16'hFC3B, 16'hFC7F, 16'hFCC0, 16'hFCFE,
		16'hFD3B, 16'hFD74, 16'hFDAC, 16'hFDE1, 16'hFE13, 16'hFE43, 16'hFE71, 16'hFE9C,
		16'hFEC4, 16'hFEEB, 16'hFF0E, 16'hFF30, 16'hFF4E, 16'hFF6B, 16'hFF85, 16'hFF9C,
		16'hFFB1, 16'hFFC4, 16'hFFD4, 16'hFFE1, 16'hFFEC, 16'hFFF5, 16'hFFFB, 16'hFFFF
	};

endpackage

FILE: design/asfp_in_if.sv
interface asfp_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] phase;
	logic [15:0] attenuation;

	modport source (output valid, output phase, output attenuation, input ready);
	modport sink (input valid, input phase, input attenuation, output ready);
endinterface

FILE: design/asfp_out_if.sv
interface asfp_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

FILE: design/asfp_cmd_if.sv
interface asfp_cmd_if;
	logic              valid;
	logic              ready;
	asfp_pkg::cmd_t    cmd;

	modport source (output valid, output cmd, input ready);
	modport sink (input valid, input cmd, output ready);
endinterface

FILE: design/asfp_front.sv
module asfp_front (
	input  logic      clk,
	input  logic      arst_n,
	asfp_in_if.sink   req,
	asfp_cmd_if.source cq
);

	logic           v_s1;
	asfp_pkg::cmd_t cmd_s1;
	asfp_pkg::cmd_t cmd_d;
	logic [14:0]    ph_half;
	logic [15:0]    ph_mirror;
	logic           take;

	assign req.ready = !v_s1 || cq.ready;
	assign take      = req.valid && req.ready;

	// fold into the first quadrant and flag the exact peak phases, the upper half only sets the sign
	always_comb begin
		ph_half   = req.phase[14:0];
		ph_mirror = 16'(asfp_pkg::PH_HALF - {1'b0, ph_half});
		cmd_d.neg = req.phase[15];
		cmd_d.att = req.attenuation;
		if ({1'b0, ph_half} > asfp_pkg::PH_QUARTER) begin
			cmd_d.ph = ph_mirror[13:0];
		end else begin
			cmd_d.ph = ph_half[13:0];
		end
		if (req.phase == asfp_pkg::PH_QUARTER) begin
			cmd_d.kind = asfp_pkg::KIND_POS_FULL;
		end else if (req.phase == asfp_pkg::PH_3QUART) begin
			cmd_d.kind = asfp_pkg::KIND_NEG_FULL;
		end else begin
			cmd_d.kind = asfp_pkg::KIND_NORM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign cq.valid = v_s1;
	assign cq.cmd   = cmd_s1;

endmodule

FILE: design/asfp_queue.sv
`include "attenuated_sine_from_phase_core_defines.svh"

module asfp_queue #(
	parameter int unsigned DEPTH = asfp_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	asfp_cmd_if.sink   wr,
	asfp_cmd_if.source rd
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	asfp_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;

	assign wr.ready = count_q != CW'(DEPTH);
	assign rd.valid = count_q != '0;
	assign rd.cmd   = mem_q[rd_ptr_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr.cmd;
		end
	end

	`ASFP_CHECK(a_count_bound, count_q <= CW'(DEPTH), "queue count beyond depth")
	`ASFP_CHECK_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1, "queue count missed a push")
	`ASFP_CHECK_NEXT(a_count_down, pop && !push, count_q == $past(count_q) - 1'b1, "queue count missed a pop")

endmodule

FILE: design/asfp_back.sv
module asfp_back (
	input  logic       clk,
	input  logic       arst_n,
	asfp_cmd_if.sink   cq,
	asfp_out_if.source rsp
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	// stage 1: table reads
	logic [1:0]  kind_s1;
	logic        neg_s1;
	logic [5:0]  fr_s1;
	logic [15:0] att_s1;
	logic [15:0] lo_s1;
	logic [16:0] hi_s1;
	logic [7:0]  k;
	logic [16:0] hi_d;

	// stage 2: interpolation
	logic [1:0]  kind_s2;
	logic        neg_s2;
	logic [15:0] att_s2;
	logic [15:0] u_s2;
	logic [6:0]  wl;
	logic [22:0] plo;
	logic [22:0] phi;
	logic [16:0] isum;

	// stage 3: gain
	logic [1:0]  kind_s3;
	logic        neg_s3;
	logic [15:0] att_s3;
	logic [15:0] m_s3;
	logic [15:0] gain2;
	logic [31:0] gprod;

	// stage 4: rounding, sign, special phases
	logic signed [15:0] sample_s4;
	logic [15:0]        gain3;
	logic [14:0]        mag;
	logic [14:0]        magr;
	logic [15:0]        sample_d;

	assign rdy_s4 = !v_s4 || rsp.ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign cq.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= cq.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// past the last entry the upper neighbor is 1.0
	assign k    = cq.cmd.ph[13:6];
	assign hi_d = (k == 8'hFF) ? 17'h10000 : {1'b0, asfp_pkg::QUARTER_ROM[8'(k + 8'd1)]};

	always_ff @(posedge clk) begin
		if (rdy_s1 && cq.valid) begin
			kind_s1 <= cq.cmd.kind;
			neg_s1  <= cq.cmd.neg;
			fr_s1   <= cq.cmd.ph[5:0];
			att_s1  <= cq.cmd.att;
			lo_s1   <= asfp_pkg::QUARTER_ROM[k];
			hi_s1   <= hi_d;
		end
	end

	// weights are (64 - f) and f in units of 1/64
	assign wl   = 7'(7'd64 - {1'b0, fr_s1});
	assign plo  = lo_s1 * wl;
	assign phi  = hi_s1 * fr_s1;
	assign isum = {1'b0, plo[21:6]} + {1'b0, phi[21:6]};

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			kind_s2 <= kind_s1;
			neg_s2  <= neg_s1;
			att_s2  <= att_s1;
			u_s2    <= isum[15:0];
		end
	end

	assign gain2 = 16'(17'h10000 - {1'b0, att_s2});
	assign gprod = u_s2 * gain2;

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			kind_s3 <= kind_s2;
			neg_s3  <= neg_s2;
			att_s3  <= att_s2;
			m_s3    <= (att_s2 == 16'h0000) ? u_s2 : gprod[31:16];
		end
	end

	assign gain3 = 16'(17'h10000 - {1'b0, att_s3});
	assign mag   = m_s3[15:1];
	assign magr  = mag + 15'((m_s3[0] && mag != asfp_pkg::POS_FULL) ? 1 : 0);

	always_comb begin
		case (kind_s3)
			asfp_pkg::KIND_POS_FULL: begin
				sample_d = (att_s3 == 16'h0000) ? {1'b0, asfp_pkg::POS_FULL} : {1'b0, gain3[15:1]};
			end
			asfp_pkg::KIND_NEG_FULL: begin
				sample_d = (att_s3 == 16'h0000) ? asfp_pkg::NEG_FULL
					: 16'(17'h10000 - {2'b00, gain3[15:1]});
			end
			default: begin
				sample_d = neg_s3 ? 16'(17'h10000 - {2'b00, magr}) : {1'b0, magr};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			sample_s4 <= sample_d;
		end
	end

	assign rsp.valid  = v_s4;
	assign rsp.sample = sample_s4;

endmodule

FILE: design/attenuated_sine_from_phase_core.sv
// channel  dir  word                         handshake
// req      in   phase[15:0], attenuation     valid/ready
// rsp      out  sample[15:0] signed Q0.15    valid/ready
//
// one word per clock sustained while rsp.ready holds, one result per word, in order
// a word goes from req through the front register, the queue and back stages 1 to 4 to rsp
// front register, command queue and four back stages each stall on their own
// arst_n clears all valid flags and queue pointers; payload is not reset
// rsp backpressure fills the back stages, then the queue and front register, then drops req.ready
module attenuated_sine_from_phase_core #(
	parameter int unsigned QUEUE_DEPTH = asfp_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	asfp_in_if.sink    req,
	asfp_out_if.source rsp
);

	asfp_cmd_if fq_ch ();
	asfp_cmd_if qb_ch ();

	asfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cq     (fq_ch)
	);

	asfp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fq_ch),
		.rd     (qb_ch)
	);

	asfp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cq     (qb_ch),
		.rsp    (rsp)
	);

endmodule

FILE: bench/asfp_sine_checker.sv
`timescale 1ns / 1ps

module asfp_sine_checker (
	input  logic clk,
	input  logic arst_n,
	asfp_in_if   req,
	asfp_out_if  rsp,
	output int   errors,
	output int   outstanding
);
	import asfp_pkg::*;

	typedef struct {
		logic [15:0] phase;
		logic [15:0] attenuation;
		logic [15:0] sample;
	} sine_expect_t;

	sine_expect_t pending_samples[$];

	// UQ0.16 times UQ0.16, truncated
	function automatic int unsigned uq16_mul(input int unsigned a, input int unsigned b);
		return ((a & 32'hFFFF) * (b & 32'hFFFF)) >> 16;
	endfunction

	function automatic logic [15:0] attenuated_sine(input logic [15:0] phase,
			input logic [15:0] attenuation);
		logic [15:0] gain;
		logic [15:0] half_gain;
		logic [15:0] folded;
		logic [15:0] mag;
		logic        neg;
		int unsigned idx;
		int unsigned frac;
		int unsigned lo;
		int unsigned hi;
		int unsigned u;
		gain = 16'h0000 - attenuation;
		half_gain = {1'b0, gain[15:1]};
		if (phase == PH_QUARTER)
			return (attenuation == 16'h0000) ? {1'b0, POS_FULL} : half_gain;
		if (phase == PH_3QUART)
			return (attenuation == 16'h0000) ? NEG_FULL : 16'h0000 - half_gain;
		neg = phase[15];
		folded = {1'b0, phase[14:0]};
		if (folded > PH_QUARTER)
			folded = PH_HALF - folded;
		idx = folded[13:6];
		frac = {folded[5:0], 10'd0};
		if (frac == 0) begin
			u = QUARTER_ROM[idx];
		end else begin
			// past the last table entry the upper neighbor is 1.0
			hi = (idx == 255) ? frac : uq16_mul(QUARTER_ROM[idx + 1], frac);
			lo = uq16_mul(QUARTER_ROM[idx], 32'h10000 - frac);
			u = (lo + hi) & 32'hFFFF;
		end
		if (attenuation != 16'h0000)
			u = uq16_mul(u, gain);
		mag = 16'(u >> 1);
		if (u[0] && mag < {1'b0, POS_FULL})
			mag = mag + 16'd1;
		return neg ? 16'h0000 - mag : mag;
	endfunction

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		sine_expect_t exp_word;
		if (!arst_n) begin
			pending_samples.delete();
			outstanding <= 0;
		end else begin
			if (req.valid && req.ready) begin
				exp_word.phase = req.phase;
				exp_word.attenuation = req.attenuation;
				exp_word.sample = attenuated_sine(req.phase, req.attenuation);
				pending_samples.push_back(exp_word);
			end
			if (rsp.valid && rsp.ready) begin
				if (pending_samples.size() == 0) begin
					$display("%0t: unexpected sample word, expected none, got %h",
						$time, rsp.sample);
					errors <= errors + 1;
				end else begin
					exp_word = pending_samples.pop_front();
					if (rsp.sample !== exp_word.sample) begin
						$display("%0t: sample mismatch (phase %h att %h) expected %h got %h",
							$time, exp_word.phase, exp_word.attenuation,
							exp_word.sample, rsp.sample);
						errors <= errors + 1;
					end
				end
			end
			outstanding <= pending_samples.size();
		end
	end
endmodule

FILE: bench/tb_attenuated_sine_from_phase_core.sv
`timescale 1ns / 1ps

module tb_attenuated_sine_from_phase_core;
	import asfp_pkg::*;

	logic clk;
	logic arst_n;
	bit   no_idle;
	int   errors;
	int   outstanding;

	asfp_in_if  req_ch ();
	asfp_out_if rsp_ch ();

	attenuated_sine_from_phase_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	asfp_sine_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.phase = 16'h0000;
		req_ch.attenuation = 16'h0000;
		rsp_ch.ready = 1'b0;
		no_idle = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic send_word(input logic [15:0] phase, input logic [15:0] attenuation);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.phase <= phase;
		req_ch.attenuation <= attenuation;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// sample sink with random stalls
	initial begin
		int gap;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 11);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
		end
	end

	initial begin
		logic [15:0] corner_phases[4];
		logic [15:0] corner_atts[4];
		logic [15:0] plain_phases[9];
		logic [15:0] ph;
		logic [15:0] att;
		int          sel;
		corner_phases = '{PH_QUARTER, PH_3QUART, 16'h0000, PH_HALF};
		corner_atts = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001};
		// last table entry with and without fraction, quadrant edges, all ones
		plain_phases = '{16'hFFFF, 16'h3FFF, 16'h3FC1, 16'h3FC0, 16'h7FFF,
			16'h0001, 16'h8001, 16'hBFFF, 16'h4001};
		@(posedge arst_n);
		@(posedge clk);
		foreach (corner_phases[i])
			foreach (corner_atts[j])
				send_word(corner_phases[i], corner_atts[j]);
		foreach (plain_phases[i])
			send_word(plain_phases[i], corner_atts[i % 4]);

		for (int n = 0; n < 2000; n++) begin
			if (n % 250 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 7);
			case (sel)
				0: ph = PH_QUARTER + 16'($urandom_range(0, 8)) - 16'd4;
				1: ph = PH_3QUART + 16'($urandom_range(0, 8)) - 16'd4;
				2: ph = {2'b00, 8'hFF, 6'($urandom)} ^ {2'($urandom_range(0, 3)), 14'd0};
				default: ph = 16'($urandom);
			endcase
			sel = $urandom_range(0, 7);
			case (sel)
				0: att = 16'h0000;
				1: att = 16'hFFFF;
				2: att = 16'($urandom_range(1, 255));
				default: att = 16'($urandom);
			endcase
			send_word(ph, att);
		end
		req_ch.valid <= 1'b0;
		no_idle = 1'b0;

		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

FILE: files.f
+incdir+design
design/asfp_pkg.sv
design/asfp_in_if.sv
design/asfp_out_if.sv
design/asfp_cmd_if.sv
design/asfp_front.sv
design/asfp_queue.sv
design/asfp_back.sv
design/attenuated_sine_from_phase_core.sv
bench/asfp_sine_checker.sv
bench/tb_attenuated_sine_from_phase_core.sv
